[rtl/dnd_pkg.sv]
// ----------------------------------------------------------------------------
// dnd_pkg: shared types and constants of the DNS name decompressor
// Sizes of the message store, the name limit, beat layouts and result codes.
// ----------------------------------------------------------------------------
package dnd_pkg;

  // message store
  localparam int MSG_DEPTH = 2048;
  localparam int ADDR_W    = $clog2(MSG_DEPTH);
  // position can run a label past the last byte, and must hold MSG_DEPTH
  localparam int POS_W     = ADDR_W + 1;

  // name length limit and counters
  localparam int NAME_MAX  = 64;
  localparam int CNT_W     = 7;
  localparam int IDX_W     = 7;
  localparam int JUMP_W    = 4;
  localparam int PTR_W     = 14;
  localparam int LEN_W     = 6;

  // beat layouts
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [7:0]        DOT_CHAR   = 8'h2e;
  localparam logic [JUMP_W-1:0] JUMPS_RST  = JUMP_W'(8);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_BAD_REF  = 2'd3
  } status_e;

  // message store access for one cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // shared position adder result
  typedef struct packed {
    logic [POS_W-1:0] sum;
    logic             oob;
  } pos_res_t;

endpackage

[rtl/dns_name_decompressor.sv]
// ----------------------------------------------------------------------------
// dns_name_decompressor: DNS name decompressor top level
// Loads message bytes and decodes compressed domain names into characters.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: op; tdata: addr[10:0], data_byte[18:11]
//  m_axis    out        tuser: char_valid; tdata: name_char[7:0],
//                       status[9:8], consumed[16:10]; tlast: last
//  cfg       in         cfg_wdata_i: max_jumps, written when cfg_we_i high
//
// A load writes its byte to the store while idle. A decode is accepted from
// idle, then walks the message through one read port and one position adder:
// each length byte, pointer byte and character is read and then used, a dot
// goes out between labels and each label end moves on to the next length
// byte, and the status beat closes the walk; s_axis_tready is low for the
// whole walk. Stalls on m_axis hold the walk at the next result. Reset clears
// the loaded top and sets max_jumps to 8; the message store is not cleared.
// ----------------------------------------------------------------------------
module dns_name_decompressor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dnd_pkg::JUMP_W-1:0]          cfg_wdata_i,   // max_jumps
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dnd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // addr, data_byte
  input  logic                                s_axis_tuser,  // op
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dnd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // name_char, status, consumed
  output logic                                m_axis_tuser,  // char_valid
  output logic                                m_axis_tlast   // last
);
  import dnd_pkg::*;

  ram_req_t          ram_req;
  logic [7:0]        ram_rdata;
  logic [POS_W-1:0]  pos;
  logic [IDX_W-1:0]  idx;
  logic [POS_W-1:0]  top;
  pos_res_t          pos_res;
  logic [7:0]        out_char;
  logic [1:0]        out_status;
  logic [CNT_W-1:0]  out_cons;

  dnd_msg_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  dnd_pos_unit u_pos (
    .pos_i (pos),
    .idx_i (idx),
    .top_i (top),
    .res_o (pos_res)
  );

  dnd_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_addr_i    (s_axis_tdata[ADDR_W-1:0]),
    .in_byte_i    (s_axis_tdata[ADDR_W+7:ADDR_W]),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata),
    .pos_o        (pos),
    .idx_o        (idx),
    .top_o        (top),
    .pos_res_i    (pos_res),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (out_char),
    .out_cv_o     (m_axis_tuser),
    .out_status_o (out_status),
    .out_cons_o   (out_cons),
    .out_last_o   (m_axis_tlast)
  );

  // result beat packing, zero padded
  assign m_axis_tdata = {(OUT_TDATA_W-CNT_W-10)'(0), out_cons, out_status, out_char};

`ifndef NO_ASSERTIONS
  // a decode beat holds off the input side on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input accepted during a name walk");

  // every result is either a character or the status beat, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != m_axis_tlast))
    else $error("result kind and last marker disagree");

  // character beats carry no status or consumed count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[OUT_TDATA_W-1:8] == '0))
    else $error("character beat with status fields set");
`endif

endmodule

[rtl/dnd_msg_ram.sv]
// ----------------------------------------------------------------------------
// dnd_msg_ram: message byte store
// One write port for loads and one registered read port for the name walk.
// ----------------------------------------------------------------------------
module dnd_msg_ram (
  input  logic              clk_i,
  input  dnd_pkg::ram_req_t req_i,
  output logic [7:0]        rdata_o
);
  import dnd_pkg::*;

  logic [7:0] mem [MSG_DEPTH];

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

[rtl/dnd_pos_unit.sv]
// ----------------------------------------------------------------------------
// dnd_pos_unit: shared position adder
// Forms the byte address of every read and checks it against the loaded top.
// ----------------------------------------------------------------------------
module dnd_pos_unit (
  input  logic [dnd_pkg::POS_W-1:0] pos_i,
  input  logic [dnd_pkg::IDX_W-1:0] idx_i,
  input  logic [dnd_pkg::POS_W-1:0] top_i,
  output dnd_pkg::pos_res_t         res_o
);
  import dnd_pkg::*;

  // base plus offset, then bound check
  always_comb begin
    res_o.sum = pos_i + POS_W'(idx_i);
    res_o.oob = (res_o.sum >= top_i);
  end

endmodule

[rtl/dnd_walker.sv]
// ----------------------------------------------------------------------------
// dnd_walker: label and pointer sequencer
// Takes load and decode beats, walks labels and pointers one byte a step
// through the shared adder, and drives the result register.
// ----------------------------------------------------------------------------
module dnd_walker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config
  input  logic                            cfg_we_i,
  input  logic [dnd_pkg::JUMP_W-1:0]      cfg_wdata_i,
  // input beat
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_op_i,
  input  logic [dnd_pkg::ADDR_W-1:0]      in_addr_i,
  input  logic [7:0]                      in_byte_i,
  // message store
  output dnd_pkg::ram_req_t               ram_req_o,
  input  logic [7:0]                      ram_rdata_i,
  // shared adder
  output logic [dnd_pkg::POS_W-1:0]       pos_o,
  output logic [dnd_pkg::IDX_W-1:0]       idx_o,
  output logic [dnd_pkg::POS_W-1:0]       top_o,
  input  dnd_pkg::pos_res_t               pos_res_i,
  // result beat
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_char_o,
  output logic                            out_cv_o,
  output logic [1:0]                      out_status_o,
  output logic [dnd_pkg::CNT_W-1:0]       out_cons_o,
  output logic                            out_last_o
);
  import dnd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_LEN_W,
    S_PTR,
    S_PTR_W,
    S_DOT,
    S_CHR,
    S_CHR_W,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  hi_q, hi_d;
  logic [JUMP_W-1:0] jumps_q, jumps_d;
  logic [CNT_W-1:0]  outcnt_q, outcnt_d;
  logic [CNT_W-1:0]  cons_q, cons_d;
  logic              jumped_q, jumped_d;
  status_e           st_q, st_d;
  logic [POS_W-1:0]  top_q, top_d;
  logic [JUMP_W-1:0] max_jumps_q, max_jumps_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_char_q, out_char_d;
  logic              out_cv_q, out_cv_d;
  logic [1:0]        out_st_q, out_st_d;
  logic [CNT_W-1:0]  out_cons_q, out_cons_d;
  logic              out_last_q, out_last_d;

  logic              slot_free;
  logic [CNT_W-1:0]  cons_inc1;
  logic [CNT_W-1:0]  cons_inc2;
  logic              name_full;
  logic [PTR_W-1:0]  ptr_off;
  logic [JUMP_W:0]   jumps_inc;
  logic [POS_W-1:0]  load_top;

  assign in_ready_o   = (state_q == S_IDLE);
  assign pos_o        = pos_q;
  assign idx_o        = idx_q;
  assign top_o        = top_q;
  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign out_cv_o     = out_cv_q;
  assign out_status_o = out_st_q;
  assign out_cons_o   = out_cons_q;
  assign out_last_o   = out_last_q;

  // helpers
  assign slot_free = !out_valid_q || out_ready_i;
  assign cons_inc1 = jumped_q ? cons_q : cons_q + CNT_W'(1);
  assign cons_inc2 = jumped_q ? cons_q : cons_q + CNT_W'(2);
  // this emit brings the count to NAME_MAX - 1
  assign name_full = ({1'b0, outcnt_q} + (CNT_W+1)'(2)) >= (CNT_W+1)'(NAME_MAX);
  assign ptr_off   = {hi_q, ram_rdata_i};
  assign jumps_inc = {1'b0, jumps_q} + (JUMP_W+1)'(1);
  assign load_top  = {1'b0, in_addr_i} + POS_W'(1);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    len_d       = len_q;
    hi_d        = hi_q;
    jumps_d     = jumps_q;
    outcnt_d    = outcnt_q;
    cons_d      = cons_q;
    jumped_d    = jumped_q;
    st_d        = st_q;
    top_d       = top_q;
    max_jumps_d = cfg_we_i ? cfg_wdata_i : max_jumps_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    out_char_d  = out_char_q;
    out_cv_d    = out_cv_q;
    out_st_d    = out_st_q;
    out_cons_d  = out_cons_q;
    out_last_d  = out_last_q;

    ram_req_o       = '0;
    ram_req_o.waddr = in_addr_i;
    ram_req_o.wdata = in_byte_i;
    ram_req_o.raddr = pos_res_i.sum[ADDR_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_e'(in_op_i) == OP_DECODE) begin
            pos_d    = {1'b0, in_addr_i};
            idx_d    = '0;
            jumps_d  = '0;
            outcnt_d = '0;
            cons_d   = '0;
            jumped_d = 1'b0;
            state_d  = S_LEN;
          end else begin
            ram_req_o.we = 1'b1;
            if (load_top > top_q) begin
              top_d = load_top;
            end
          end
        end
      end
      // read the length or pointer byte
      S_LEN: begin
        if (pos_res_i.oob) begin
          st_d    = ST_BAD_REF;
          state_d = S_FIN;
        end else begin
          ram_req_o.re = 1'b1;
          state_d      = S_LEN_W;
        end
      end
      S_LEN_W: begin
        len_d = ram_rdata_i[LEN_W-1:0];
        hi_d  = ram_rdata_i[LEN_W-1:0];
        idx_d = IDX_W'(1);
        if (ram_rdata_i[7:6] != 2'b00) begin
          state_d = S_PTR;
        end else if (ram_rdata_i == 8'h00) begin
          cons_d  = cons_inc1;
          st_d    = ST_OK;
          state_d = S_FIN;
        end else if (outcnt_q != '0) begin
          state_d = S_DOT;
        end else begin
          cons_d  = cons_inc1;
          state_d = S_CHR;
        end
      end
      // second pointer byte
      S_PTR: begin
        if (pos_res_i.oob) begin
          st_d    = ST_BAD_REF;
          state_d = S_FIN;
        end else begin
          ram_req_o.re = 1'b1;
          state_d      = S_PTR_W;
        end
      end
      S_PTR_W: begin
        cons_d   = cons_inc2;
        jumped_d = 1'b1;
        if (ptr_off == '0 || ptr_off >= PTR_W'(top_q)) begin
          st_d    = ST_BAD_REF;
          state_d = S_FIN;
        end else begin
          jumps_d = jumps_inc[JUMP_W-1:0];
          if (jumps_inc >= {1'b0, max_jumps_q}) begin
            st_d    = ST_TOO_MANY;
            state_d = S_FIN;
          end else begin
            pos_d   = ptr_off[POS_W-1:0];
            idx_d   = '0;
            state_d = S_LEN;
          end
        end
      end
      // dot between labels
      S_DOT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = DOT_CHAR;
          out_cv_d    = 1'b1;
          out_st_d    = ST_OK;
          out_cons_d  = '0;
          out_last_d  = 1'b0;
          outcnt_d    = outcnt_q + CNT_W'(1);
          if (name_full) begin
            st_d    = ST_TOO_LONG;
            state_d = S_FIN;
          end else begin
            cons_d  = cons_inc1;
            state_d = S_CHR;
          end
        end
      end
      // label characters, idx runs 1..len
      S_CHR: begin
        if (idx_q > IDX_W'(len_q)) begin
          pos_d   = pos_res_i.sum;
          idx_d   = '0;
          state_d = S_LEN;
        end else if (pos_res_i.oob) begin
          st_d    = ST_BAD_REF;
          state_d = S_FIN;
        end else begin
          ram_req_o.re = 1'b1;
          state_d      = S_CHR_W;
        end
      end
      S_CHR_W: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ram_rdata_i;
          out_cv_d    = 1'b1;
          out_st_d    = ST_OK;
          out_cons_d  = '0;
          out_last_d  = 1'b0;
          outcnt_d    = outcnt_q + CNT_W'(1);
          if (name_full) begin
            st_d    = ST_TOO_LONG;
            state_d = S_FIN;
          end else begin
            cons_d  = cons_inc1;
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_CHR;
          end
        end
      end
      // status beat
      S_FIN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = 8'h00;
          out_cv_d    = 1'b0;
          out_st_d    = st_q;
          out_cons_d  = cons_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      idx_q       <= '0;
      len_q       <= '0;
      hi_q        <= '0;
      jumps_q     <= '0;
      outcnt_q    <= '0;
      cons_q      <= '0;
      jumped_q    <= 1'b0;
      st_q        <= ST_OK;
      top_q       <= '0;
      max_jumps_q <= JUMPS_RST;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_cv_q    <= 1'b0;
      out_st_q    <= '0;
      out_cons_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      hi_q        <= hi_d;
      jumps_q     <= jumps_d;
      outcnt_q    <= outcnt_d;
      cons_q      <= cons_d;
      jumped_q    <= jumped_d;
      st_q        <= st_d;
      top_q       <= top_d;
      max_jumps_q <= max_jumps_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_cv_q    <= out_cv_d;
      out_st_q    <= out_st_d;
      out_cons_q  <= out_cons_d;
      out_last_q  <= out_last_d;
    end
  end

endmodule

[tb/sv/dnd_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dnd_scoreboard_pkg: name scoreboard for the DNS name decompressor test
// Mirrors the message store and the jump limit. For every accepted decode it
// walks labels and pointers itself and queues the expected output beats.
// ----------------------------------------------------------------------------
package dnd_scoreboard_pkg;
  import dnd_pkg::*;

  // one expected output beat
  typedef struct packed {
    logic [7:0] name_char;
    logic       char_valid;
    status_e    status;
    logic [6:0] consumed;
    logic       last;
  } name_beat_t;

  class name_scoreboard;
    localparam int REPORT_CAP = 100;

    logic [7:0]        msg_bytes [MSG_DEPTH];
    bit                written   [MSG_DEPTH];
    int                loaded_top = 0;
    logic [JUMP_W-1:0] max_jumps = JUMPS_RST;
    int                hole_at;
    int                errors = 0;
    int                beats_seen = 0;
    name_beat_t        walk_beats[$];
    name_beat_t        name_beats_due[$];

    // read one message byte; false at or past the loaded top
    function bit byte_at(int p, output logic [7:0] b);
      b = 8'h00;
      if (p >= loaded_top) return 1'b0;
      if (!written[p]) begin
        if (hole_at < 0) hole_at = p;
      end else begin
        b = msg_bytes[p];
      end
      return 1'b1;
    endfunction

    // walk the name at start into walk_beats; returns the first unwritten
    // byte touched below the top, or -1
    function int decode_name(logic [ADDR_W-1:0] start);
      int               pos;
      int               jumps;
      int               out_n;
      int               cons;
      bit               jumped;
      bit               done;
      logic [7:0]       len;
      logic [7:0]       lo;
      logic [7:0]       ch;
      logic [PTR_W-1:0] tgt;
      status_e          st;
      pos     = int'(start);
      jumps   = 0;
      out_n   = 0;
      cons    = 0;
      jumped  = 1'b0;
      done    = 1'b0;
      st      = ST_OK;
      hole_at = -1;
      walk_beats.delete();
      while (!done) begin
        if (!byte_at(pos, len)) begin
          st = ST_BAD_REF;
          break;
        end
        // compression pointer
        if (len[7:6] != 2'b00) begin
          if (!byte_at(pos + 1, lo)) begin
            st = ST_BAD_REF;
            break;
          end
          tgt = {len[5:0], lo};
          if (!jumped) cons += 2;
          jumped = 1'b1;
          if (tgt == '0 || int'(tgt) >= loaded_top) begin
            st = ST_BAD_REF;
            break;
          end
          jumps++;
          if (jumps >= int'(max_jumps)) begin
            st = ST_TOO_MANY;
            break;
          end
          pos = int'(tgt);
          continue;
        end
        // end of name
        if (len == 8'h00) begin
          if (!jumped) cons++;
          break;
        end
        // dot ahead of every label but the first
        if (out_n > 0) begin
          walk_beats.push_back('{DOT_CHAR, 1'b1, ST_OK, 7'd0, 1'b0});
          out_n++;
          if (out_n + 1 >= NAME_MAX) begin
            st = ST_TOO_LONG;
            break;
          end
        end
        if (!jumped) cons++;
        for (int i = 0; i < int'(len); i++) begin
          if (!byte_at(pos + 1 + i, ch)) begin
            st   = ST_BAD_REF;
            done = 1'b1;
            break;
          end
          walk_beats.push_back('{ch, 1'b1, ST_OK, 7'd0, 1'b0});
          out_n++;
          if (out_n + 1 >= NAME_MAX) begin
            st   = ST_TOO_LONG;
            done = 1'b1;
            break;
          end
          if (!jumped) cons++;
        end
        pos += 1 + int'(len);
      end
      walk_beats.push_back('{8'h00, 1'b0, st, 7'(cons), 1'b1});
      return hole_at;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // accepted input beat: store a byte or queue a decoded name
    task note_item(logic op, logic [ADDR_W-1:0] addr, logic [7:0] data);
      if (op_e'(op) == OP_LOAD) begin
        msg_bytes[addr] = data;
        written[addr]   = 1'b1;
        if (int'(addr) + 1 > loaded_top) loaded_top = int'(addr) + 1;
      end else begin
        void'(decode_name(addr));
        foreach (walk_beats[k]) name_beats_due.push_back(walk_beats[k]);
      end
    endtask

    // accepted output beat against the oldest one due
    task check_beat(logic [OUT_TDATA_W-1:0] tdata, logic tuser, logic tlast);
      name_beat_t exp_b;
      beats_seen++;
      if (name_beats_due.size() == 0) begin
        report($sformatf("beat %0d with nothing due: tdata=%h tuser=%b tlast=%b",
                         beats_seen, tdata, tuser, tlast));
        return;
      end
      exp_b = name_beats_due.pop_front();
      if (tdata[7:0] !== exp_b.name_char)
        report($sformatf("beat %0d name_char %h, want %h",
                         beats_seen, tdata[7:0], exp_b.name_char));
      if (tuser !== exp_b.char_valid)
        report($sformatf("beat %0d char_valid %b, want %b",
                         beats_seen, tuser, exp_b.char_valid));
      if (tdata[9:8] !== exp_b.status)
        report($sformatf("beat %0d status %0d, want %0d",
                         beats_seen, tdata[9:8], exp_b.status));
      if (tdata[16:10] !== exp_b.consumed)
        report($sformatf("beat %0d consumed %0d, want %0d",
                         beats_seen, tdata[16:10], exp_b.consumed));
      if (tlast !== exp_b.last)
        report($sformatf("beat %0d last %b, want %b", beats_seen, tlast, exp_b.last));
    endtask
  endclass

endpackage

[tb/sv/dns_name_decompressor_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_name_decompressor_test: stream test of the DNS name decompressor
// Builds small messages of labels and compression pointers through load
// beats, decodes names in them under several jump limits and checks every
// output beat against the scoreboard, with random idling on both streams.
// ----------------------------------------------------------------------------
module dns_name_decompressor_test;
  import dnd_pkg::*;
  import dnd_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [JUMP_W-1:0]      cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // addr[10:0], data_byte[18:11]
  logic                   s_axis_tuser;   // op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // name_char[7:0], status[9:8], consumed[16:10]
  logic                   m_axis_tuser;   // char_valid
  logic                   m_axis_tlast;   // last

  name_scoreboard sb;
  int unsigned    cycle_cnt = 0;
  int             item_cnt  = 0;
  int             wcur      = 0;   // next free message address
  int             names[$];        // start offsets of well-formed names
  bit             calm      = 1'b0;
  bit             hold_req  = 1'b0;

  dns_name_decompressor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle count and timeout
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("dns_name_decompressor_test: errors");
    $finish;
  end

  // beats on both streams go to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(s_axis_tuser, s_axis_tdata[10:0], s_axis_tdata[18:11]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 19);
    end
  end

  // one input beat; entered and left at a falling edge, valid stays up
  task automatic send_item(op_e op, logic [ADDR_W-1:0] addr, logic [7:0] data);
    while (!calm && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    item_cnt++;
  endtask

  task automatic put_byte(logic [7:0] d);
    send_item(OP_LOAD, ADDR_W'(wcur), d);
    wcur++;
  endtask

  task automatic put_labels(int n_labels, int max_len);
    int len;
    repeat (n_labels) begin
      len = $urandom_range(max_len, 1);
      put_byte(8'(len));
      repeat (len) put_byte(8'($urandom_range(255)));
    end
  endtask

  // pointer with a random non-zero prefix
  task automatic put_pointer(logic [PTR_W-1:0] tgt);
    put_byte({2'($urandom_range(3, 1)), tgt[13:8]});
    put_byte(tgt[7:0]);
  endtask

  // decode, first filling any unwritten byte the walk would read
  task automatic decode_at(logic [ADDR_W-1:0] a);
    int hole;
    hole = sb.decode_name(a);
    while (hole >= 0) begin
      send_item(OP_LOAD, ADDR_W'(hole), 8'($urandom_range(255)));
      hole = sb.decode_name(a);
    end
    send_item(OP_DECODE, a, 8'($urandom_range(255)));
  endtask

  // stop offering and wait out every result due
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.name_beats_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_max_jumps(logic [JUMP_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.max_jumps = v;
  endtask

  // random episodes: about half well-formed names, the rest noise and broken ones
  task automatic run_phase(int n_items);
    int goal;
    int kind;
    int start;
    int len;
    goal = item_cnt + n_items;
    while (item_cnt < goal) begin
      if (wcur > 1900) wcur = 1;
      kind  = $urandom_range(99);
      start = wcur;
      if (kind < 50) begin
        // labels ending in a root or a pointer to an earlier name
        put_labels($urandom_range(4, 1), 8);
        if (names.size() > 0 && $urandom_range(1))
          put_pointer(PTR_W'(names[$urandom_range(names.size() - 1)]));
        else
          put_byte(8'h00);
        names.push_back(start);
        decode_at(ADDR_W'(start));
        if ($urandom_range(2) == 0)
          decode_at(ADDR_W'(names[$urandom_range(names.size() - 1)]));
      end else if (kind < 66) begin
        // decode at an arbitrary offset
        if ($urandom_range(1))
          decode_at(ADDR_W'($urandom_range(wcur + 4)));
        else
          decode_at(ADDR_W'($urandom_range(2047)));
      end else if (kind < 80) begin
        // name that points back at itself
        put_labels($urandom_range(3, 1), 12);
        put_pointer(PTR_W'(start));
        decode_at(ADDR_W'(start));
      end else if (kind < 90) begin
        // pointer to zero or past the loaded top
        put_labels($urandom_range(2), 6);
        if ($urandom_range(1))
          put_pointer('0);
        else
          put_pointer(PTR_W'($urandom_range(16383, wcur + 2)));
        decode_at(ADDR_W'(start));
      end else begin
        // name cut off at the loaded top
        put_labels($urandom_range(2), 6);
        if ($urandom_range(1)) begin
          len = $urandom_range(20, 2);
          put_byte(8'(len));
          repeat ($urandom_range(len - 1)) put_byte(8'($urandom_range(255)));
        end else begin
          put_byte({2'($urandom_range(3, 1)), 6'($urandom_range(63))});
        end
        decode_at(ADDR_W'(start));
      end
    end
  endtask

  initial begin
    sb            = new;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, with the reset jump limit
    decode_at(11'd0);                          // nothing loaded yet
    decode_at(11'h7ff);
    put_byte(8'h00);                           // root at 0
    decode_at(11'd0);
    put_byte(8'd3); put_byte(8'h61); put_byte(8'h62); put_byte(8'h63);
    put_byte(8'd2); put_byte(8'h7a); put_byte(8'h7a); put_byte(8'h00);
    names.push_back(1);                        // abc.zz at 1
    put_byte(8'd1); put_byte(8'hff);           // one-byte label, then
    put_byte(8'hc0); put_byte(8'h01);          // pointer to abc.zz
    names.push_back(9);
    decode_at(11'd9);
    put_byte(8'h80); put_byte(8'h00);          // pointer to offset zero
    decode_at(11'd13);
    put_byte(8'h7f); put_byte(8'hff);          // pointer far past the top
    decode_at(11'd15);
    put_byte(8'hc0); put_byte(8'd17);          // pointer to itself
    decode_at(11'd17);
    put_byte(8'd5); put_byte(8'h41);           // label running past the top
    decode_at(11'd19);

    // random phases under different jump limits
    wait_drained();
    set_max_jumps(4'd1);
    run_phase(80);

    wait_drained();
    set_max_jumps(4'd15);
    calm = 1'b1;
    run_phase(70);
    calm = 1'b0;

    wait_drained();
    set_max_jumps(4'd0);
    run_phase(50);

    wait_drained();
    set_max_jumps(4'd3);
    hold_req = 1'b1;                           // receiver holds off a while
    run_phase(80);

    wait_drained();
    set_max_jumps(4'($urandom_range(15, 1)));
    run_phase(70);

    // top of the store: loaded top reaches the full depth
    send_item(OP_LOAD, 11'h7ff, 8'hff);
    decode_at(11'h7ff);                        // pointer's low byte past the store
    decode_at(ADDR_W'(names[0]));

    wait_drained();
    if (sb.errors == 0) begin
      $display("dns_name_decompressor_test: clean");
    end else begin
      $display("dns_name_decompressor_test: errors");
    end
    $finish;
  end

endmodule
